/* hw/rtl/hrrn_pkg.sv */
// Package for the HRRN process queue: widths, status and mode codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hrrn_pkg;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdW   = 8;
  localparam int unsigned TimeW = 16;
  localparam int unsigned RatioW = 17;
  localparam int unsigned FillW = 5;

  localparam logic [1:0] ModeEnq  = 2'd0;
  localparam logic [1:0] ModeDeq  = 2'd1;
  localparam logic [1:0] ModeHrrn = 2'd2;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StZero  = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic load_in;     // capture input transfer
    logic append;      // write tail slot, count++
    logic scan_start;  // ratio scan: reset index and best
    logic div_start;   // start divide for current scan index
    logic scan_next;   // compare quotient, advance index
    logic take_head;   // choose slot 0
    logic rd_sel;      // read chosen entry fields
    logic shift_step;  // move entry k+1 into k
    logic shift_done;  // count--
    logic set_result;  // build result register
  } hrrn_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] mode;
    logic       cpu_zero;
    logic       full;
    logic       empty;
    logic       div_busy;
    logic       scan_last;
    logic       shift_last;
  } hrrn_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/hrrn_divider.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module hrrn_divider #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              busy_o,
  output logic [W-1:0]      quot_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [W:0]    trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; quo_d = num_i;
      den_d = (den_i == '0) ? W'(1) : den_i;
      cnt_d = CW'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign busy_o = busy_q | start_i;
  assign quot_o = quo_q;
endmodule
`default_nettype wire

/* hw/rtl/hrrn_datapath.sv */
// Queue storage, ratio scan and shifting removal for the HRRN queue.
// Depends on hrrn_pkg and hrrn_divider.
`timescale 1ns / 1ps
`default_nettype none
module hrrn_datapath #(
  parameter int unsigned QUEUE_DEPTH = hrrn_pkg::QueueDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire hrrn_pkg::hrrn_cmd_t         cmd_i,
  output hrrn_pkg::hrrn_stat_t             stat_o,
  input  wire logic [1:0]                  mode_i,
  input  wire logic [hrrn_pkg::IdW-1:0]    proc_id_i,
  input  wire logic [hrrn_pkg::TimeW-1:0]  arrival_time_i,
  input  wire logic [hrrn_pkg::TimeW-1:0]  cpu_time_i,
  input  wire logic [hrrn_pkg::TimeW-1:0]  now_time_i,
  output logic [1:0]                       status_o,
  output logic [hrrn_pkg::IdW-1:0]         out_id_o,
  output logic [hrrn_pkg::TimeW-1:0]       out_arrival_o,
  output logic [hrrn_pkg::TimeW-1:0]       out_cpu_o,
  output logic [hrrn_pkg::RatioW-1:0]      out_ratio_o,
  output logic [hrrn_pkg::FillW-1:0]       fill_level_o
);
  import hrrn_pkg::*;
  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // storage: small register arrays, read at the scan/shift index and at the chosen entry
  logic [IdW-1:0]   id_q  [QUEUE_DEPTH];
  logic [TimeW-1:0] arr_q [QUEUE_DEPTH];
  logic [TimeW-1:0] cpu_q [QUEUE_DEPTH];
  logic [CW-1:0]    cnt_q;

  logic [1:0]       mode_q;
  logic [IdW-1:0]   pid_q;
  logic [TimeW-1:0] a_q, c_q, now_q;
  logic [IW-1:0]    idx_q, best_q;
  logic [RatioW-1:0] best_r_q;
  logic [1:0]       st_q;
  logic [IdW-1:0]   oid_q;
  logic [TimeW-1:0] oarr_q, ocpu_q;
  logic [RatioW-1:0] orat_q;
  logic             taken_q;   // an entry was read out for this transfer

  logic [TimeW-1:0] wait_v, quot;
  logic [RatioW-1:0] ratio_v;
  logic [IW-1:0]    idx_nx;
  logic             div_busy;
  logic             idx_at_end;

  assign wait_v = (now_q >= arr_q[idx_q]) ? now_q - arr_q[idx_q] : '0;
  assign ratio_v = {1'b0, quot} + RatioW'(1);
  assign idx_nx = idx_q + IW'(1);
  assign idx_at_end = ((CW+1)'(idx_q) + (CW+1)'(1) >= (CW+1)'(cnt_q));

  hrrn_divider #(.W(TimeW)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start), .num_i(wait_v), .den_i(cpu_q[idx_q]),
    .busy_o(div_busy), .quot_o(quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.append) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.shift_done) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i; pid_q <= proc_id_i; a_q <= arrival_time_i;
      c_q <= cpu_time_i; now_q <= now_time_i;
      taken_q <= 1'b0;
    end
    if (cmd_i.append) begin
      id_q[cnt_q[IW-1:0]]  <= pid_q;
      arr_q[cnt_q[IW-1:0]] <= a_q;
      cpu_q[cnt_q[IW-1:0]] <= c_q;
    end
    if (cmd_i.scan_start) begin
      idx_q <= '0; best_q <= '0; best_r_q <= '0;
    end
    if (cmd_i.scan_next) begin
      if (ratio_v > best_r_q) begin
        best_r_q <= ratio_v; best_q <= idx_q;
      end
      idx_q <= idx_nx;
    end
    if (cmd_i.take_head) begin
      best_q <= '0;
    end
    if (cmd_i.rd_sel) begin
      oid_q <= id_q[best_q]; oarr_q <= arr_q[best_q]; ocpu_q <= cpu_q[best_q];
      idx_q <= best_q;
      taken_q <= 1'b1;
    end
    if (cmd_i.shift_step) begin
      id_q[idx_q]  <= id_q[idx_nx];
      arr_q[idx_q] <= arr_q[idx_nx];
      cpu_q[idx_q] <= cpu_q[idx_nx];
      idx_q <= idx_nx;
    end
    if (cmd_i.set_result) begin
      case (mode_q)
        ModeEnq: begin
          st_q <= (c_q == '0) ? StZero :
                  (cnt_q >= CW'(QUEUE_DEPTH)) ? StFull : StOk;
          oid_q <= '0; oarr_q <= '0; ocpu_q <= '0; orat_q <= '0;
        end
        ModeDeq, ModeHrrn: begin
          if (!taken_q) begin
            st_q <= StEmpty;
            oid_q <= '0; oarr_q <= '0; ocpu_q <= '0; orat_q <= '0;
          end else begin
            // entry fields already captured by the read-out
            st_q <= StOk;
            orat_q <= (mode_q == ModeHrrn) ? best_r_q : '0;
          end
        end
        default: begin
          st_q <= StOk;
          oid_q <= '0; oarr_q <= '0; ocpu_q <= '0; orat_q <= '0;
        end
      endcase
    end
  end

  assign stat_o.mode       = mode_q;
  assign stat_o.cpu_zero   = (c_q == '0);
  assign stat_o.full       = (cnt_q >= CW'(QUEUE_DEPTH));
  assign stat_o.empty      = (cnt_q == '0);
  assign stat_o.div_busy   = div_busy;
  assign stat_o.scan_last  = idx_at_end;
  assign stat_o.shift_last = idx_at_end;

  assign status_o      = st_q;
  assign out_id_o      = oid_q;
  assign out_arrival_o = oarr_q;
  assign out_cpu_o     = ocpu_q;
  assign out_ratio_o   = orat_q;
  assign fill_level_o  = FillW'(cnt_q);
endmodule
`default_nettype wire

/* hw/rtl/hrrn_ctrl.sv */
// Sequencer for the HRRN queue: handshake and datapath commands.
// Depends on hrrn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hrrn_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire hrrn_pkg::hrrn_stat_t stat_i,
  output hrrn_pkg::hrrn_cmd_t       cmd_o
);
  import hrrn_pkg::*;
  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SDec   = 9'b000000010,
    SDivGo = 9'b000000100,
    SDivW  = 9'b000001000,
    SRead  = 9'b000010000,
    SShift = 9'b000100000,
    SRes   = 9'b001000000,
    SOut   = 9'b010000000,
    SFin   = 9'b100000000
  } state_e;
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   rem_pend_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o = '0;
    case (state_q)
      SIdle: if (in_valid_i && !out_valid_q) begin
        cmd_o.load_in = 1'b1; state_d = SDec;
      end
      SDec: begin
        state_d = SRes;
        case (stat_i.mode)
          ModeEnq: if (!stat_i.cpu_zero && !stat_i.full) begin
            state_d = SFin;
          end
          ModeDeq: if (!stat_i.empty) begin
            cmd_o.take_head = 1'b1; state_d = SRead;
          end
          ModeHrrn: if (!stat_i.empty) begin
            cmd_o.scan_start = 1'b1; state_d = SDivGo;
          end
          default: state_d = SRes;
        endcase
      end
      SDivGo: begin
        cmd_o.div_start = 1'b1; state_d = SDivW;
      end
      SDivW: if (!stat_i.div_busy) begin
        cmd_o.scan_next = 1'b1;
        state_d = stat_i.scan_last ? SRead : SDivGo;
      end
      SRead: begin
        cmd_o.rd_sel = 1'b1; state_d = SShift;
      end
      SShift: begin
        if (stat_i.shift_last) begin
          cmd_o.shift_done = 1'b1; state_d = SOut;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      SFin: begin
        cmd_o.set_result = 1'b1; cmd_o.append = 1'b1; state_d = SOut;
      end
      SRes: begin
        cmd_o.set_result = 1'b1; state_d = SOut;
      end
      SOut: begin
        // the removal path lands here without a result yet:
        // build it once the count has dropped
        if (rem_pend_q) begin
          cmd_o.set_result = 1'b1;
        end else if (!out_valid_q) begin
          state_d = SIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; out_valid_q <= 1'b0; rem_pend_q <= 1'b0;
    end else begin
      state_q <= state_d; out_valid_q <= out_valid_d;
      rem_pend_q <= (state_q == SShift && stat_i.shift_last);
    end
  end

  assign in_stall_o  = (state_q != SIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_o) else $error("input taken while result pending");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == SDivW) else $error("divide not awaited");
endmodule
`default_nettype wire

/* hw/rtl/hrrn_process_queue_core.sv */
// HRRN process queue top level: controller plus datapath.
// Depends on hrrn_pkg, hrrn_ctrl, hrrn_datapath, hrrn_divider.
// Flow: enqueue or empty/failed ops decode, then build the result; dequeue reads the head
//   and shifts the later entries up; ratio dequeue runs one serial divide per entry,
//   keeps the best ratio, then reads the chosen entry and closes up the gap behind it.
// Throughput: one item at a time; next transfer after the result is taken.
// Reset: rst_ni async low clears the entry count and control; stores stay as written.
`timescale 1ns / 1ps
`default_nettype none
module hrrn_process_queue_core #(
  parameter int unsigned QUEUE_DEPTH = hrrn_pkg::QueueDepth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  mode_i,
  input  wire logic [hrrn_pkg::IdW-1:0]    proc_id_i,
  input  wire logic [hrrn_pkg::TimeW-1:0]  arrival_time_i,
  input  wire logic [hrrn_pkg::TimeW-1:0]  cpu_time_i,
  input  wire logic [hrrn_pkg::TimeW-1:0]  now_time_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic [hrrn_pkg::IdW-1:0]         out_id_o,
  output logic [hrrn_pkg::TimeW-1:0]       out_arrival_o,
  output logic [hrrn_pkg::TimeW-1:0]       out_cpu_o,
  output logic [hrrn_pkg::RatioW-1:0]      out_ratio_o,
  output logic [hrrn_pkg::FillW-1:0]       fill_level_o
);
  import hrrn_pkg::*;
  hrrn_cmd_t  cmd;
  hrrn_stat_t stat;

  // controller owns the handshakes; datapath owns queue and result
  hrrn_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  hrrn_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .mode_i, .proc_id_i, .arrival_time_i, .cpu_time_i, .now_time_i,
    .status_o, .out_id_o, .out_arrival_o, .out_cpu_o, .out_ratio_o, .fill_level_o
  );
endmodule
`default_nettype wire

/* tb/hrrn_process_queue_core_test.sv */
// Testbench for the HRRN process queue core: directed and random transfers checked
// against a behavioral queue model. Depends on hrrn_pkg and hrrn_process_queue_core.
`timescale 1ns / 1ps
module hrrn_process_queue_core_test;
  import hrrn_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] cpu;
    logic [RatioW-1:0] ratio;
    logic [FillW-1:0] fill;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [1:0] mode_i = '0;
  logic [IdW-1:0] proc_id_i = '0;
  logic [TimeW-1:0] arrival_time_i = '0;
  logic [TimeW-1:0] cpu_time_i = '0;
  logic [TimeW-1:0] now_time_i = '0;
  logic out_stall_i = 1'b0;
  wire in_stall_o, out_valid_o;
  wire [1:0] status_o;
  wire [IdW-1:0] out_id_o;
  wire [TimeW-1:0] out_arrival_o, out_cpu_o;
  wire [RatioW-1:0] out_ratio_o;
  wire [FillW-1:0] fill_level_o;

  hrrn_process_queue_core u_top (.*);

  always #5 clk_i = ~clk_i;

  // Queue model: slot 0 is the head.
  logic [IdW-1:0]   q_id[$];
  logic [TimeW-1:0] q_arr[$];
  logic [TimeW-1:0] q_cpu[$];
  sched_result_t expected_results[$];
  int errors = 0;
  int unsigned cycle_count = 0;
  int hold_cycles = 0;   // forced long receiver hold-off
  bit rand_out_stall = 1'b1;

  function automatic sched_result_t predict_schedule(logic [1:0] mode, logic [IdW-1:0] pid,
      logic [TimeW-1:0] arr, logic [TimeW-1:0] cpu, logic [TimeW-1:0] now);
    sched_result_t r;
    int best;
    int unsigned best_ratio, rt, wt, dv;
    r = '0;
    if (mode == ModeEnq) begin
      if (cpu == 0) r.status = StZero;
      else if (q_id.size() >= QueueDepth) r.status = StFull;
      else begin
        q_id.push_back(pid); q_arr.push_back(arr); q_cpu.push_back(cpu);
      end
    end else if (mode == ModeDeq || mode == ModeHrrn) begin
      if (q_id.size() == 0) r.status = StEmpty;
      else begin
        best = 0;
        best_ratio = 0;
        if (mode == ModeHrrn) begin
          for (int k = 0; k < q_id.size(); k++) begin
            wt = (now >= q_arr[k]) ? 32'(now) - 32'(q_arr[k]) : 0;
            dv = (q_cpu[k] == 0) ? 1 : 32'(q_cpu[k]);
            rt = wt / dv + 1;
            if (rt > best_ratio) begin
              best_ratio = rt;
              best = k;
            end
          end
          r.ratio = RatioW'(best_ratio);
        end
        r.id = q_id[best]; r.arrival = q_arr[best]; r.cpu = q_cpu[best];
        q_id.delete(best); q_arr.delete(best); q_cpu.delete(best);
      end
    end
    r.fill = FillW'(q_id.size());
    return r;
  endfunction

  // Send one transfer after a random gap; prediction made on acceptance.
  // Valid stays high after acceptance until the next call or a drain decides.
  task automatic send_item(logic [1:0] mode, logic [IdW-1:0] pid, logic [TimeW-1:0] arr,
      logic [TimeW-1:0] cpu, logic [TimeW-1:0] now, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode; proc_id_i <= pid; arrival_time_i <= arr;
    cpu_time_i <= cpu; now_time_i <= now;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(predict_schedule(mode, pid, arr, cpu, now));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall: random per result, or a forced long hold-off.
  always @(posedge clk_i) begin : stall_gen
    int cnt;
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
      cnt = 0;
    end else if (cnt > 0) begin
      cnt = cnt - 1;
      out_stall_i <= 1'b1;
    end else if (out_valid_o && !out_stall_i || !out_stall_i && $urandom_range(0, 7) == 0) begin
      cnt = rand_out_stall ? $urandom_range(0, 17) : 0;
      out_stall_i <= (cnt > 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    sched_result_t e;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (out_id_o !== e.id) begin
          $error("out_id exp %0d got %0d", e.id, out_id_o); errors++;
        end
        if (out_arrival_o !== e.arrival) begin
          $error("out_arrival exp %0d got %0d", e.arrival, out_arrival_o); errors++;
        end
        if (out_cpu_o !== e.cpu) begin
          $error("out_cpu exp %0d got %0d", e.cpu, out_cpu_o); errors++;
        end
        if (out_ratio_o !== e.ratio) begin
          $error("out_ratio exp %0d got %0d", e.ratio, out_ratio_o); errors++;
        end
        if (fill_level_o !== e.fill) begin
          $error("fill_level exp %0d got %0d", e.fill, fill_level_o); errors++;
        end
      end
    end
    if (cycle_count > 3_000_000) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [TimeW-1:0] rand_time();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return TimeW'($urandom);
    endcase
  endfunction

  // Empty queue, both dequeue modes, zero cpu, mode 3.
  task automatic test_empty_cases();
    send_item(ModeDeq, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ModeHrrn, 8'h00, 16'h0, 16'h0, 16'h0);
    send_item(ModeEnq, 8'hAA, 16'h1234, 16'h0, 16'h0);
    send_item(2'd3, 8'h55, 16'h1, 16'h1, 16'h1);
  endtask

  // Fill to full, overflow, zero cpu when full, ties, arrival after now.
  task automatic test_full_and_ratio();
    for (int k = 0; k < QueueDepth; k++)
      send_item(ModeEnq, IdW'(k * 17), (k == 3) ? 16'hFFFF : TimeW'(10 * k),
                (k < 2) ? 16'd1 : 16'hFFFF, 16'd0);
    send_item(ModeEnq, 8'hFF, 16'h0, 16'h5, 16'h0);
    send_item(ModeEnq, 8'hFF, 16'h0, 16'h0, 16'h0);
    send_item(ModeHrrn, 8'h0, 16'h0, 16'h0, 16'd0);      // all ratio 1: head wins
    send_item(ModeHrrn, 8'h0, 16'h0, 16'h0, 16'hFFFF);   // max wait, cpu 1
    send_item(ModeDeq, 8'h0, 16'h0, 16'h0, 16'h0);
    send_item(ModeHrrn, 8'h0, 16'h0, 16'h0, 16'd5);
    drain_results();
  endtask

  // Random well-formed mixes; hold-off and pause phases included.
  task automatic test_random(int n);
    logic [1:0] m;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) hold_cycles = 2500;
      if (i == n / 2) drain_results();
      case ($urandom_range(0, 19))
        0: m = 2'd3;
        1, 2, 3, 4, 5, 6, 7, 8: m = ModeEnq;
        9, 10, 11: m = ModeDeq;
        default: m = ModeHrrn;
      endcase
      send_item(m, IdW'($urandom), rand_time(),
                ($urandom_range(0, 15) == 0) ? 16'h0 :
                ($urandom_range(0, 1) ? TimeW'($urandom_range(1, 64)) : rand_time() | 16'h1),
                rand_time(), i % 200 < 20);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_cases();
    test_full_and_ratio();
    test_random(1830);
    drain_results();
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

/* hrrn_process_queue_core.f */
hw/rtl/hrrn_pkg.sv
hw/rtl/hrrn_divider.sv
hw/rtl/hrrn_datapath.sv
hw/rtl/hrrn_ctrl.sv
hw/rtl/hrrn_process_queue_core.sv
tb/hrrn_process_queue_core_test.sv
